@@ src/cbim_pkg.sv @@
`default_nettype none

package cbim_pkg;

    typedef logic [7:0]  t_byte;
    typedef logic [14:0] t_count;

    // Transaction kinds
    localparam logic [1:0] REQ_LOW_READ   = 2'd0;
    localparam logic [1:0] REQ_LOW_WRITE  = 2'd1;
    localparam logic [1:0] REQ_HIGH_WRITE = 2'd2;
    localparam logic [1:0] REQ_TICK       = 2'd3;

    // Address decode masks
    localparam logic [15:0] LOW_DEC_MASK  = 16'hF800;
    localparam logic [15:0] HIGH_DEC_MASK = 16'hF003;

    // Low-area decodes
    localparam logic [15:0] LOW_CNT_LO = 16'h5000;
    localparam logic [15:0] LOW_CNT_HI = 16'h5800;

    // High-area decodes
    localparam logic [15:0] HI_PROG0   = 16'h8000;
    localparam logic [15:0] HI_MIRROR  = 16'h9000;
    localparam logic [15:0] HI_PROG1   = 16'hA000;
    localparam logic [15:0] HI_PAT0    = 16'hB000;
    localparam logic [15:0] HI_PAT1    = 16'hB002;
    localparam logic [15:0] HI_PAT2    = 16'hC000;
    localparam logic [15:0] HI_PAT3    = 16'hC002;
    localparam logic [15:0] HI_PAT4    = 16'hD000;
    localparam logic [15:0] HI_PAT5    = 16'hD002;
    localparam logic [15:0] HI_PAT6    = 16'hE000;
    localparam logic [15:0] HI_PAT7    = 16'hE002;
    localparam logic [15:0] HI_IRQ     = 16'hF001;

    // Counter constants
    localparam t_count COUNT_MAX   = 15'h7FFF;
    localparam t_byte  BIAS_LARGE  = 8'h12;
    localparam t_byte  BIAS_NORMAL = 8'h10;
    localparam t_byte  PAT_SPECIAL = 8'h20;
    localparam int     MIRROR_BIT  = 6;

    // Configuration register addresses
    localparam logic [0:0] CFG_LARGE_PAT_ROM = 1'b0;

endpackage

`default_nettype wire

@@ src/cartridge_bank_and_irq_mapper.sv @@
// The result is shown in the cycle after the input is accepted.
// Throughput: one transaction per cycle; the input stalls only while a
// shown result is itself stalled.
// Reset (i_rst_n low, synchronous): banks return to their power-up map,
// the counter, enable and interrupt clear, and no result is shown.
`default_nettype none

module cartridge_bank_and_irq_mapper (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [0:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    // request channel
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [1:0]  i_req_type,
    input  wire logic [15:0] i_addr,
    input  wire logic [7:0]  i_data,
    input  wire logic [7:0]  i_cycles,
    input  wire logic [2:0]  i_pattern_slot,
    // result channel
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [7:0]       o_read_data,
    output logic             o_irq_line,
    output logic             o_mirror_horizontal,
    output logic [7:0]       o_prog_bank_8000,
    output logic [7:0]       o_prog_bank_a000,
    output logic [7:0]       o_pattern_bank
);

    // Mapper state
    logic              r_large_pat_rom;
    cbim_pkg::t_count  r_irq_count,   n_irq_count;
    cbim_pkg::t_byte   r_cnt_arm,     n_cnt_arm;
    cbim_pkg::t_byte   r_pat_banks [8];
    cbim_pkg::t_byte   n_pat_banks [8];
    cbim_pkg::t_byte   r_prog0,       n_prog0;
    cbim_pkg::t_byte   r_prog1,       n_prog1;
    logic              r_mirror,      n_mirror;
    logic              r_irq,         n_irq;

    // Result register
    logic              r_out_valid;
    cbim_pkg::t_byte   r_read_data,   n_read_data;
    cbim_pkg::t_byte   r_pat_out;

    logic              in_accept;
    logic              cfg_write;
    logic [15:0]       low_dec;
    logic [15:0]       high_dec;
    logic [8:0]        biased_sum;
    cbim_pkg::t_byte   bias;
    cbim_pkg::t_byte   hi_value;
    logic [15:0]       tick_sum;

    assign o_in_stall = r_out_valid && i_out_stall;
    assign in_accept  = i_in_valid && !o_in_stall;

    // APB access
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr == cbim_pkg::CFG_LARGE_PAT_ROM) ?
                       {31'd0, r_large_pat_rom} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_large_pat_rom <= 1'b0;
        end else if (cfg_write && paddr == cbim_pkg::CFG_LARGE_PAT_ROM) begin
            r_large_pat_rom <= pwdata[0];
        end
    end

    assign low_dec  = i_addr & cbim_pkg::LOW_DEC_MASK;
    assign high_dec = i_addr & cbim_pkg::HIGH_DEC_MASK;

    // Biased, halved counter high byte; zero stays zero
    assign bias       = (r_pat_banks[0] == cbim_pkg::PAT_SPECIAL) ?
                        cbim_pkg::BIAS_LARGE : cbim_pkg::BIAS_NORMAL;
    assign biased_sum = {1'b0, i_data} + {1'b0, bias};
    assign hi_value   = (i_data == 8'd0) ? 8'd0 : biased_sum[8:1];

    assign tick_sum = {1'b0, r_irq_count} + {8'd0, i_cycles};

    // Next state and read value for one transaction
    always_comb begin
        n_irq_count  = r_irq_count;
        n_cnt_arm    = r_cnt_arm;
        n_pat_banks  = r_pat_banks;
        n_prog0      = r_prog0;
        n_prog1      = r_prog1;
        n_mirror     = r_mirror;
        n_irq        = r_irq;
        n_read_data  = 8'd0;

        case (i_req_type)
            cbim_pkg::REQ_LOW_READ: begin
                if (low_dec == cbim_pkg::LOW_CNT_LO) begin
                    n_read_data = r_irq_count[7:0];
                end else if (low_dec == cbim_pkg::LOW_CNT_HI) begin
                    n_read_data = {1'b0, r_irq_count[14:8]};
                end else begin
                    n_read_data = i_addr[15:8];
                end
            end
            cbim_pkg::REQ_LOW_WRITE: begin
                if (low_dec == cbim_pkg::LOW_CNT_LO) begin
                    n_irq_count = {r_irq_count[14:8], i_data};
                    n_irq       = 1'b0;
                end
            end
            cbim_pkg::REQ_HIGH_WRITE: begin
                case (high_dec)
                    cbim_pkg::HI_PROG0:  n_prog0 = i_data;
                    cbim_pkg::HI_MIRROR: begin
                        if (r_large_pat_rom) begin
                            n_mirror = i_data[cbim_pkg::MIRROR_BIT];
                        end
                    end
                    cbim_pkg::HI_PROG1:  n_prog1 = i_data;
                    cbim_pkg::HI_PAT0:   n_pat_banks[0] = i_data;
                    cbim_pkg::HI_PAT1:   n_pat_banks[1] = i_data;
                    cbim_pkg::HI_PAT2:   n_pat_banks[2] = i_data;
                    cbim_pkg::HI_PAT3:   n_pat_banks[3] = i_data;
                    cbim_pkg::HI_PAT4:   n_pat_banks[4] = i_data;
                    cbim_pkg::HI_PAT5:   n_pat_banks[5] = i_data;
                    cbim_pkg::HI_PAT6:   n_pat_banks[6] = i_data;
                    cbim_pkg::HI_PAT7:   n_pat_banks[7] = i_data;
                    cbim_pkg::HI_IRQ: begin
                        n_irq_count = {hi_value[6:0], r_irq_count[7:0]};
                        n_cnt_arm   = hi_value;
                        n_irq       = 1'b0;
                    end
                    default: ;
                endcase
            end
            cbim_pkg::REQ_TICK: begin
                // saturating add while enabled
                if (r_cnt_arm != 8'd0) begin
                    if (tick_sum >= {1'b0, cbim_pkg::COUNT_MAX}) begin
                        n_irq_count = cbim_pkg::COUNT_MAX;
                        n_cnt_arm   = 8'd0;
                        n_irq       = 1'b1;
                    end else begin
                        n_irq_count = tick_sum[14:0];
                    end
                end
            end
            default: ;
        endcase
    end

    // State update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_irq_count  <= '0;
            r_cnt_arm    <= '0;
            r_prog0      <= 8'd0;
            r_prog1      <= 8'd1;
            r_mirror     <= 1'b0;
            r_irq        <= 1'b0;
            for (int i = 0; i < 8; i++) begin
                r_pat_banks[i] <= 8'(i);
            end
        end else if (in_accept) begin
            r_irq_count  <= n_irq_count;
            r_cnt_arm    <= n_cnt_arm;
            r_prog0      <= n_prog0;
            r_prog1      <= n_prog1;
            r_mirror     <= n_mirror;
            r_irq        <= n_irq;
            r_pat_banks  <= n_pat_banks;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_read_data <= n_read_data;
            r_pat_out   <= n_pat_banks[i_pattern_slot];
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_read_data         = r_read_data;
    assign o_irq_line          = r_irq;
    assign o_mirror_horizontal = r_mirror;
    assign o_prog_bank_8000    = r_prog0;
    assign o_prog_bank_a000    = r_prog1;
    assign o_pattern_bank      = r_pat_out;

endmodule

`default_nettype wire

@@ src/cbim_checker.sv @@
`default_nettype none

module cbim_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        o_in_stall,
    input wire logic [1:0]  i_req_type,
    input wire logic [15:0] i_addr,
    input wire logic [7:0]  i_data,
    input wire logic        o_out_valid,
    input wire logic        i_out_stall,
    input wire logic [7:0]  o_read_data,
    input wire logic [7:0]  o_prog_bank_8000
);

    logic in_accept;
    assign in_accept = i_in_valid && !o_in_stall;

    // Reset leaves no result on show
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result shown after reset");

    // Every accepted transaction shows a result next cycle
    a_accept_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> o_out_valid)
        else $error("accepted transaction gave no result");

    // A stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_read_data))
        else $error("stalled result changed");

    // Only low reads carry read data
    a_read_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept && i_req_type != cbim_pkg::REQ_LOW_READ |=> o_read_data == 8'd0)
        else $error("read data on a non-read transaction");

    // Program bank write lands at once
    a_prog0_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept && i_req_type == cbim_pkg::REQ_HIGH_WRITE &&
        (i_addr & cbim_pkg::HIGH_DEC_MASK) == cbim_pkg::HI_PROG0
        |=> o_prog_bank_8000 == $past(i_data))
        else $error("program bank write lost");

endmodule

bind cartridge_bank_and_irq_mapper cbim_checker u_cbim_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in_valid),
    .o_in_stall       (o_in_stall),
    .i_req_type       (i_req_type),
    .i_addr           (i_addr),
    .i_data           (i_data),
    .o_out_valid      (o_out_valid),
    .i_out_stall      (i_out_stall),
    .o_read_data      (o_read_data),
    .o_prog_bank_8000 (o_prog_bank_8000)
);

`default_nettype wire
